// File: design/fcrg_pkg.sv
package fcrg_pkg;

  // Neighbor table geometry
  localparam int NEIGHBORS = 16;
  localparam int NB_W      = 4;
  localparam int CNT_W     = 32;
  localparam int SEQ_W     = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Request commands
  typedef enum logic [1:0] {
    CMD_TX      = 2'd0,
    CMD_RX_FULL = 2'd1,
    CMD_RX_SUPP = 2'd2,
    CMD_INIT    = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REPLAY    = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  // Saturating increment of a frame counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

// File: design/fcrg_req_if.sv
interface fcrg_req_if;
  logic                          valid;
  logic                          ready;
  fcrg_pkg::cmd_t                command;
  logic [fcrg_pkg::NB_W-1:0]     neighbor;
  logic                          is_broadcast;
  logic [fcrg_pkg::CNT_W-1:0]    rx_counter;
  logic [fcrg_pkg::SEQ_W-1:0]    seqno;

  modport source (output valid, command, neighbor, is_broadcast, rx_counter, seqno,
                  input ready);
  modport sink   (input valid, command, neighbor, is_broadcast, rx_counter, seqno,
                  output ready);
endinterface

// File: design/fcrg_rsp_if.sv
interface fcrg_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fcrg_pkg::CNT_W-1:0]    counter_value;
  logic [1:0]                    status;
  logic [fcrg_pkg::SEQ_W-1:0]    seq_byte;

  modport source (output valid, counter_value, status, seq_byte, input ready);
  modport sink   (input valid, counter_value, status, seq_byte, output ready);
endinterface

// File: design/frame_counter_replay_guard.sv
// Frame counter replay guard.
// A request enters the input register when accepted and its result enters
// the result register when the output advances. Throughput: one request
// per cycle unless the result side stalls; the per-neighbor table
// read-modify-write sits in the single execute stage between those registers.
// Reset (rst, synchronous): all counters, the neighbor table and the mode clear.
module frame_counter_replay_guard (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  fcrg_req_if.sink          req,
  fcrg_rsp_if.source        rsp
);

  localparam int CW = fcrg_pkg::CNT_W;
  localparam int NW = fcrg_pkg::NB_W;
  localparam int SW = fcrg_pkg::SEQ_W;

  // Mode register
  logic suppression_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      suppression_mode <= 1'b0;
    end else if (cfg_we) begin
      suppression_mode <= cfg_wdata;
    end
  end

  // Input register
  logic                 s1_valid;
  fcrg_pkg::cmd_t       s1_command;
  logic [NW-1:0]        s1_neighbor;
  logic                 s1_bcast;
  logic [CW-1:0]        s1_rx_counter;
  logic [SW-1:0]        s1_seqno;
  logic                 advance;
  logic                 exec;

  assign advance   = !rsp.valid || rsp.ready;
  assign exec      = s1_valid && advance;
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_command    <= req.command;
      s1_neighbor   <= req.neighbor;
      s1_bcast      <= req.is_broadcast;
      s1_rx_counter <= req.rx_counter;
      s1_seqno      <= req.seqno;
    end
  end

  // Counter state
  logic [CW-1:0] peer_bcast_counter [fcrg_pkg::NEIGHBORS];
  logic [CW-1:0] peer_ucast_counter [fcrg_pkg::NEIGHBORS];
  logic [CW-1:0] own_ucast_to_peer  [fcrg_pkg::NEIGHBORS];
  logic [CW-1:0] own_bcast_counter;
  logic [CW-1:0] own_ucast_global;

  // Execute: table lookup for the request in the input register
  logic          nb_ok;
  logic [CW-1:0] rd_pb, rd_pu, rd_ou, slot;
  logic [CW-1:0] ob_inc, g_inc, ou_inc;
  logic [CW-SW-1:0] upper;
  logic [CW-1:0] rebuilt;

  assign nb_ok   = {1'b0, s1_neighbor} < (NW+1)'(fcrg_pkg::NEIGHBORS);
  assign rd_pb   = peer_bcast_counter[s1_neighbor];
  assign rd_pu   = peer_ucast_counter[s1_neighbor];
  assign rd_ou   = own_ucast_to_peer[s1_neighbor];
  assign slot    = s1_bcast ? rd_pb : rd_pu;
  assign ob_inc  = fcrg_pkg::sat_inc(own_bcast_counter);
  assign g_inc   = fcrg_pkg::sat_inc(own_ucast_global);
  assign ou_inc  = fcrg_pkg::sat_inc(rd_ou);
  // rebuild full counter from seqno: bump upper part when seqno wrapped
  assign upper   = slot[CW-1:SW] + (CW-SW)'(s1_seqno < slot[SW-1:0]);
  assign rebuilt = {upper, s1_seqno};

  logic              wr_ob, wr_g, wr_pb, wr_pu, wr_ou;
  logic [CW-1:0]     wd_peer, wd_ou;
  logic [CW-1:0]     res_value;
  fcrg_pkg::status_t res_status;

  always_comb begin
    wr_ob      = 1'b0;
    wr_g       = 1'b0;
    wr_pb      = 1'b0;
    wr_pu      = 1'b0;
    wr_ou      = 1'b0;
    wd_peer    = '0;
    wd_ou      = ou_inc;
    res_value  = '0;
    res_status = fcrg_pkg::ST_OK;
    unique case (s1_command)
      fcrg_pkg::CMD_TX: begin
        if (!suppression_mode || s1_bcast) begin
          wr_ob     = 1'b1;
          res_value = ob_inc;
          if (ob_inc == fcrg_pkg::CNT_MAX) res_status = fcrg_pkg::ST_EXHAUSTED;
        end else if (!nb_ok) begin
          res_status = fcrg_pkg::ST_EXHAUSTED;
        end else begin
          wr_g = 1'b1;
          if (g_inc == fcrg_pkg::CNT_MAX) begin
            res_status = fcrg_pkg::ST_EXHAUSTED;
          end else begin
            wr_ou     = 1'b1;
            res_value = ou_inc;
            if (ou_inc == fcrg_pkg::CNT_MAX) res_status = fcrg_pkg::ST_EXHAUSTED;
          end
        end
      end
      fcrg_pkg::CMD_RX_FULL: begin
        if (!nb_ok) begin
          res_status = fcrg_pkg::ST_REPLAY;
        end else begin
          res_value = s1_rx_counter;
          wd_peer   = s1_rx_counter;
          if (s1_rx_counter > slot) begin
            wr_pb = s1_bcast;
            wr_pu = !s1_bcast;
          end else begin
            res_status = fcrg_pkg::ST_REPLAY;
          end
        end
      end
      fcrg_pkg::CMD_RX_SUPP: begin
        if (!nb_ok || !suppression_mode) begin
          res_status = fcrg_pkg::ST_REPLAY;
        end else begin
          res_value = rebuilt;
          wd_peer   = rebuilt;
          if (rebuilt > slot) begin
            wr_pb = s1_bcast;
            wr_pu = !s1_bcast;
          end else begin
            res_status = fcrg_pkg::ST_REPLAY;
          end
        end
      end
      fcrg_pkg::CMD_INIT: begin
        if (nb_ok) begin
          wr_pb   = 1'b1;
          wr_pu   = 1'b1;
          wr_ou   = 1'b1;
          wd_peer = '0;
          wd_ou   = suppression_mode ? own_ucast_global : '0;
        end
      end
      default: ;
    endcase
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      own_bcast_counter <= '0;
      own_ucast_global  <= '0;
      for (int i = 0; i < fcrg_pkg::NEIGHBORS; i++) begin
        peer_bcast_counter[i] <= '0;
        peer_ucast_counter[i] <= '0;
        own_ucast_to_peer[i]  <= '0;
      end
    end else if (exec) begin
      if (wr_ob) own_bcast_counter <= ob_inc;
      if (wr_g)  own_ucast_global  <= g_inc;
      if (wr_pb) peer_bcast_counter[s1_neighbor] <= wd_peer;
      if (wr_pu) peer_ucast_counter[s1_neighbor] <= wd_peer;
      if (wr_ou) own_ucast_to_peer[s1_neighbor]  <= wd_ou;
    end
  end

  // Result register
  logic [CW-1:0] out_value;
  logic [1:0]    out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  assign rsp.counter_value = out_value;
  assign rsp.status        = out_status;
  assign rsp.seq_byte      = out_value[SW-1:0];

  // Checks
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("pending request dropped while result stalled");

  a_bcast_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> own_bcast_counter >= $past(own_bcast_counter))
    else $error("broadcast transmit counter went backwards");

  a_global_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> own_ucast_global >= $past(own_ucast_global))
    else $error("global unicast counter went backwards");

  a_rx_no_tx_change: assert property (@(posedge clk) disable iff (rst)
    exec && s1_command != fcrg_pkg::CMD_TX |=>
      $stable(own_bcast_counter) && $stable(own_ucast_global))
    else $error("non-transmit request changed a transmit counter");

  a_exhausted_value: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == fcrg_pkg::ST_EXHAUSTED |->
      rsp.counter_value == fcrg_pkg::CNT_MAX || rsp.counter_value == '0)
    else $error("exhausted status with a usable counter");

endmodule

// File: sim/tb_top.sv
module tb_top;
  import fcrg_pkg::*;

  localparam int LONG_HOLD  = 300;   // receiver hold-off that backs up the pipeline
  localparam int IDLE_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int MAX_REPORT = 10;

  // One request as driven on the request channel
  typedef struct packed {
    cmd_t             cmd;
    logic [NB_W-1:0]  nb;
    logic             bcast;
    logic [CNT_W-1:0] rxc;
    logic [SEQ_W-1:0] seq;
  } guard_req_t;

  // One result as seen on the result channel
  typedef struct packed {
    logic [CNT_W-1:0] counter_value;
    status_t          status;
    logic [SEQ_W-1:0] seq_byte;
  } guard_rsp_t;

  // Directed row: mode to run in, request, and optionally a hand-typed result
  typedef struct packed {
    logic       mode;
    guard_req_t stim;
    logic       typed;
    guard_rsp_t known;
  } dir_row_t;

  localparam guard_rsp_t NONE = '{32'h0, ST_OK, 8'h00};

  localparam int NUM_DIR = 26;
  dir_row_t dir_rows [NUM_DIR] = '{
    // mode 0: shared transmit counter
    '{1'b0, '{CMD_TX,      4'd0,  1'b0, 32'h0,        8'h00}, 1'b1, '{32'd1, ST_OK, 8'h01}},
    '{1'b0, '{CMD_TX,      4'd5,  1'b1, 32'h0,        8'h00}, 1'b1, '{32'd2, ST_OK, 8'h02}},
    '{1'b0, '{CMD_RX_FULL, 4'd0,  1'b0, 32'h0,        8'h00}, 1'b1,
      '{32'h0, ST_REPLAY, 8'h00}},
    '{1'b0, '{CMD_RX_FULL, 4'd0,  1'b0, 32'h1,        8'h00}, 1'b1, '{32'h1, ST_OK, 8'h01}},
    '{1'b0, '{CMD_RX_FULL, 4'd0,  1'b0, 32'h1,        8'h00}, 1'b1,
      '{32'h1, ST_REPLAY, 8'h01}},
    '{1'b0, '{CMD_RX_FULL, 4'd15, 1'b1, 32'hFFFFFFFF, 8'h00}, 1'b1,
      '{32'hFFFFFFFF, ST_OK, 8'hFF}},
    '{1'b0, '{CMD_RX_FULL, 4'd15, 1'b1, 32'hFFFFFFFE, 8'h00}, 1'b1,
      '{32'hFFFFFFFE, ST_REPLAY, 8'hFE}},
    '{1'b0, '{CMD_RX_FULL, 4'd15, 1'b1, 32'hFFFFFFFF, 8'h00}, 1'b1,
      '{32'hFFFFFFFF, ST_REPLAY, 8'hFF}},
    // suppressed receive is refused in mode 0
    '{1'b0, '{CMD_RX_SUPP, 4'd3,  1'b0, 32'h0,        8'hFF}, 1'b1,
      '{32'h0, ST_REPLAY, 8'h00}},
    '{1'b0, '{CMD_INIT,    4'd15, 1'b0, 32'h0,        8'h00}, 1'b1, NONE},
    '{1'b0, '{CMD_RX_FULL, 4'd15, 1'b1, 32'h1,        8'h00}, 1'b0, NONE},
    // mode 1: split broadcast / per-neighbor unicast counters
    '{1'b1, '{CMD_TX,      4'd2,  1'b0, 32'h0,        8'h00}, 1'b1, '{32'd1, ST_OK, 8'h01}},
    '{1'b1, '{CMD_TX,      4'd2,  1'b0, 32'h0,        8'h00}, 1'b0, NONE},
    '{1'b1, '{CMD_TX,      4'd9,  1'b1, 32'h0,        8'h00}, 1'b0, NONE},
    '{1'b1, '{CMD_INIT,    4'd7,  1'b0, 32'h0,        8'h00}, 1'b1, NONE},
    '{1'b1, '{CMD_TX,      4'd7,  1'b0, 32'h0,        8'h00}, 1'b0, NONE},
    // sequence rebuild: carry into upper bits, equal replay, top of byte
    '{1'b1, '{CMD_RX_FULL, 4'd4,  1'b0, 32'h123456F0, 8'h00}, 1'b0, NONE},
    '{1'b1, '{CMD_RX_SUPP, 4'd4,  1'b0, 32'h0,        8'h10}, 1'b0, NONE},
    '{1'b1, '{CMD_RX_SUPP, 4'd4,  1'b0, 32'h0,        8'h10}, 1'b0, NONE},
    '{1'b1, '{CMD_RX_SUPP, 4'd4,  1'b0, 32'h0,        8'hFF}, 1'b0, NONE},
    // upper 24 bits wrap to zero, which is then a replay
    '{1'b1, '{CMD_RX_FULL, 4'd9,  1'b1, 32'hFFFFFF80, 8'h00}, 1'b0, NONE},
    '{1'b1, '{CMD_RX_SUPP, 4'd9,  1'b1, 32'h0,        8'h00}, 1'b0, NONE},
    '{1'b1, '{CMD_RX_SUPP, 4'd9,  1'b1, 32'h0,        8'hFF}, 1'b0, NONE},
    '{1'b1, '{CMD_INIT,    4'd4,  1'b0, 32'h0,        8'h00}, 1'b1, NONE},
    '{1'b1, '{CMD_RX_SUPP, 4'd4,  1'b0, 32'h0,        8'h00}, 1'b0, NONE},
    '{1'b1, '{CMD_RX_SUPP, 4'd4,  1'b0, 32'h0,        8'h01}, 1'b0, NONE}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  fcrg_req_if req_ch ();
  fcrg_rsp_if rsp_ch ();

  frame_counter_replay_guard DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #4 clk = ~clk;

  // Predicted guard state
  logic [CNT_W-1:0] heard_bcast [NEIGHBORS];
  logic [CNT_W-1:0] heard_ucast [NEIGHBORS];
  logic [CNT_W-1:0] sent_ucast_to [NEIGHBORS];
  logic [CNT_W-1:0] sent_bcast_cnt = '0;
  logic [CNT_W-1:0] sent_ucast_glob = '0;
  logic             split_mode = 1'b0;

  guard_rsp_t pending_guard_results [$];
  int         fail_count = 0;
  logic       hold_request = 1'b0;
  int         send_calm = 0;

  initial begin
    for (int i = 0; i < NEIGHBORS; i++) begin
      heard_bcast[i]   = '0;
      heard_ucast[i]   = '0;
      sent_ucast_to[i] = '0;
    end
  end

  function automatic logic [CNT_W-1:0] bump_saturating(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Replay test against the stored counter of one peer; stores on accept
  function automatic status_t accept_if_newer(input logic bcast, input int nb,
                                              input logic [CNT_W-1:0] val);
    logic [CNT_W-1:0] stored;
    stored = bcast ? heard_bcast[nb] : heard_ucast[nb];
    if (val <= stored) return ST_REPLAY;
    if (bcast) heard_bcast[nb] = val;
    else       heard_ucast[nb] = val;
    return ST_OK;
  endfunction

  // Result of one request, advancing the predicted state
  function automatic guard_rsp_t next_guard_result(input guard_req_t r);
    guard_rsp_t       o;
    logic             nb_ok;
    int               nb;
    logic [CNT_W-1:0] stored;
    logic [23:0]      hi;
    o = NONE;
    nb = int'(r.nb);
    nb_ok = nb < NEIGHBORS;
    case (r.cmd)
      CMD_TX: begin
        if (!split_mode || r.bcast) begin
          sent_bcast_cnt = bump_saturating(sent_bcast_cnt);
          o.counter_value = sent_bcast_cnt;
          if (sent_bcast_cnt == CNT_MAX) o.status = ST_EXHAUSTED;
        end else if (!nb_ok) begin
          o.status = ST_EXHAUSTED;
        end else begin
          // global counter first; exhausted global leaves the peer counter alone
          sent_ucast_glob = bump_saturating(sent_ucast_glob);
          if (sent_ucast_glob == CNT_MAX) begin
            o.status = ST_EXHAUSTED;
          end else begin
            sent_ucast_to[nb] = bump_saturating(sent_ucast_to[nb]);
            o.counter_value = sent_ucast_to[nb];
            if (o.counter_value == CNT_MAX) o.status = ST_EXHAUSTED;
          end
        end
      end
      CMD_RX_FULL: begin
        if (!nb_ok) begin
          o.status = ST_REPLAY;
        end else begin
          o.counter_value = r.rxc;
          o.status = accept_if_newer(r.bcast, nb, r.rxc);
        end
      end
      CMD_RX_SUPP: begin
        if (!nb_ok || !split_mode) begin
          o.status = ST_REPLAY;
        end else begin
          stored = r.bcast ? heard_bcast[nb] : heard_ucast[nb];
          hi = stored[31:8];
          if (r.seq < stored[7:0]) hi = hi + 24'd1;
          o.counter_value = {hi, r.seq};
          o.status = accept_if_newer(r.bcast, nb, o.counter_value);
        end
      end
      default: begin
        if (nb_ok) begin
          heard_bcast[nb]   = '0;
          heard_ucast[nb]   = '0;
          sent_ucast_to[nb] = split_mode ? sent_ucast_glob : '0;
        end
      end
    endcase
    o.seq_byte = o.counter_value[7:0];
    return o;
  endfunction

  // Random request, mostly aimed close to the stored counters so that
  // accepts and replays both come up often
  function automatic guard_req_t random_request();
    guard_req_t       r;
    int               pick;
    logic [CNT_W-1:0] stored;
    r.nb    = NB_W'($urandom_range(0, NEIGHBORS - 1));
    r.bcast = 1'($urandom_range(0, 1));
    r.rxc   = $urandom;
    r.seq   = SEQ_W'($urandom_range(0, 255));
    stored  = r.bcast ? heard_bcast[r.nb] : heard_ucast[r.nb];
    pick    = $urandom_range(0, 99);
    if (pick < 22) begin
      r.cmd = CMD_TX;
    end else if (pick < 54) begin
      r.cmd = CMD_RX_FULL;
      case ($urandom_range(0, 9))
        0: r.rxc = stored;
        1: r.rxc = stored - CNT_W'($urandom_range(1, 50));
        2: ;  // fully random counter
        3: r.rxc = $urandom_range(0, 1) ? CNT_MAX : '0;
        default: r.rxc = stored + CNT_W'($urandom_range(1, 300));
      endcase
    end else if (pick < 91) begin
      r.cmd = CMD_RX_SUPP;
      if ($urandom_range(0, 7) != 0)
        r.seq = stored[7:0] + SEQ_W'($urandom_range(0, 60)) - 8'd12;
    end else begin
      r.cmd = CMD_INIT;
    end
    return r;
  endfunction

  // Offer one request, wait for the handshake, then maybe idle
  task automatic send_request(input guard_req_t r, input logic typed,
                              input guard_rsp_t known);
    guard_rsp_t pred;
    int         gap;
    int         pick;
    req_ch.valid        <= 1'b1;
    req_ch.command      <= r.cmd;
    req_ch.neighbor     <= r.nb;
    req_ch.is_broadcast <= r.bcast;
    req_ch.rx_counter   <= r.rxc;
    req_ch.seqno        <= r.seq;
    do @(posedge clk); while (!req_ch.ready);
    pred = next_guard_result(r);
    pending_guard_results.push_back(typed ? known : pred);
    gap = 0;
    if (send_calm > 0) begin
      send_calm--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 25)      gap = $urandom_range(1, 3);
      else if (pick < 28) gap = $urandom_range(10, 40);
      else if (pick < 31) send_calm = $urandom_range(40, 120);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mode register write, only once the pipeline has drained
  task automatic set_mode(input logic m);
    req_ch.valid <= 1'b0;
    while (pending_guard_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    split_mode = m;
  endtask

  task automatic run_random(input int count, input logic with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 120) hold_request <= 1'b1;
      send_request(random_request(), 1'b0, NONE);
    end
  endtask

  // Stimulus
  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.command      = CMD_TX;
    req_ch.neighbor     = '0;
    req_ch.is_broadcast = 1'b0;
    req_ch.rx_counter   = '0;
    req_ch.seqno        = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_mode(1'b0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != split_mode) set_mode(dir_rows[i].mode);
      send_request(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].known);
    end

    // The 32-bit transmit counters cannot be walked to exhaustion in a run
    // of this length, so that status only shows up if the design misbehaves.
    run_random(500, 1'b1);
    set_mode(1'b0);
    run_random(350, 1'b0);
    set_mode(1'b1);
    run_random(600, 1'b0);

    req_ch.valid <= 1'b0;
    while (pending_guard_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result receiver: checks each result and drives ready with random stalls
  initial begin
    int         stall_left;
    int         calm_left;
    int         pick;
    logic       hold_done;
    guard_rsp_t want;
    stall_left = 0;
    calm_left  = 0;
    hold_done  = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (pending_guard_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORT)
            $display("result with no request waiting: value %h status %0d",
                     rsp_ch.counter_value, rsp_ch.status);
        end else begin
          want = pending_guard_results.pop_front();
          if (rsp_ch.counter_value !== want.counter_value ||
              rsp_ch.status !== want.status || rsp_ch.seq_byte !== want.seq_byte) begin
            fail_count++;
            if (fail_count <= MAX_REPORT)
              $display("mismatch: want value %h status %0d byte %h, got %h %0d %h",
                       want.counter_value, want.status, want.seq_byte,
                       rsp_ch.counter_value, rsp_ch.status, rsp_ch.seq_byte);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
        // long hold-off so the block fills up and stalls its input
        hold_done  = 1'b1;
        stall_left = LONG_HOLD - 1;
        rsp_ch.ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        rsp_ch.ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          stall_left = $urandom_range(0, 2);
          rsp_ch.ready <= 1'b0;
        end else if (pick < 14) begin
          stall_left = $urandom_range(10, 40);
          rsp_ch.ready <= 1'b0;
        end else if (pick < 17) begin
          calm_left = $urandom_range(40, 120);
          rsp_ch.ready <= 1'b1;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog on handshake activity
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
